>>> rtl/core/max_flow_edmonds_karp_top_assert.svh
// Assertion macros for the max-flow engine; clk and rst_n must be in scope.
`ifndef MAX_FLOW_EDMONDS_KARP_TOP_ASSERT_SVH
`define MAX_FLOW_EDMONDS_KARP_TOP_ASSERT_SVH
`ifndef SYNTH
`define MFEK_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mfek check failed");
`define MFEK_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mfek check failed");
`else
`define MFEK_ASSERT_HOLDS(lbl, expr)
`define MFEK_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/core/mfek_pkg.sv
package mfek_pkg;

    localparam int NODE_W  = 6;
    localparam int CAP_W   = 48;
    localparam int FLOW_W  = 56;
    localparam int TOTAL_W = 54;
    localparam int RES_W   = 58;
    localparam int PUSH_W  = 61;

    localparam logic [CAP_W-1:0]   CAP_MAX    = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
    localparam logic [PUSH_W-1:0]  PUSH_START = 61'd1000000000000000000;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic [0:0] REG_SOURCE = 1'd0;
    localparam logic [0:0] REG_SINK   = 1'd1;

    typedef enum logic [4:0] {
        S_CLR_ALL,
        S_IDLE,
        S_CAP_RD,
        S_CAP_WR,
        S_CLR_FLOW,
        S_BFS_INIT,
        S_DEQ_RD,
        S_DEQ,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PATH_INIT,
        S_MIN_PAR,
        S_MIN_EDGE,
        S_MIN_ACC,
        S_UPD_PAR,
        S_UPD_EDGE,
        S_UPD_FWD,
        S_UPD_REV,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_CAP_RD,
        DP_CAP_WR,
        DP_CLR_ALL,
        DP_CLR_FLOW,
        DP_BFS_INIT,
        DP_DEQ_RD,
        DP_DEQ,
        DP_SCAN_RD,
        DP_SCAN_CHK,
        DP_PATH_INIT,
        DP_MIN_PAR,
        DP_MIN_EDGE,
        DP_MIN_ACC,
        DP_UPD_INIT,
        DP_UPD_PAR,
        DP_UPD_EDGE,
        DP_UPD_FWD,
        DP_UPD_REV,
        DP_TOTAL,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic run_bad;
        logic q_empty;
        logic v_last;
        logic hit_dst;
        logic at_src;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/mfek_ctrl.sv
module mfek_ctrl
    import mfek_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    input  dp_status_t status,
    output logic       in_ready,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_ALL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR_ALL:
            begin
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_CLEAR: state_next = S_CLR_ALL;
                        OP_ADD:   state_next = S_CAP_RD;
                        OP_RUN:   state_next = S_CLR_FLOW;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_CAP_RD:   state_next = S_CAP_WR;
            S_CAP_WR:   state_next = S_IDLE;
            S_CLR_FLOW:
            begin
                if (status.sweep_last)
                begin
                    state_next = status.run_bad ? S_EMIT : S_BFS_INIT;
                end
            end
            S_BFS_INIT: state_next = S_DEQ_RD;
            S_DEQ_RD:   state_next = status.q_empty ? S_EMIT : S_DEQ;
            S_DEQ:      state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (status.hit_dst)
                begin
                    state_next = S_PATH_INIT;
                end
                else if (status.v_last)
                begin
                    state_next = S_DEQ_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_PATH_INIT: state_next = S_MIN_PAR;
            S_MIN_PAR:   state_next = status.at_src ? S_UPD_PAR : S_MIN_EDGE;
            S_MIN_EDGE:  state_next = S_MIN_ACC;
            S_MIN_ACC:   state_next = S_MIN_PAR;
            S_UPD_PAR:   state_next = status.at_src ? S_BFS_INIT : S_UPD_EDGE;
            S_UPD_EDGE:  state_next = S_UPD_FWD;
            S_UPD_FWD:   state_next = S_UPD_REV;
            S_UPD_REV:   state_next = S_UPD_PAR;
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = DP_IDLE;
        case (state_reg)
            S_CLR_ALL:   cmd.op = DP_CLR_ALL;
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? DP_LOAD : DP_IDLE;
            end
            S_CAP_RD:    cmd.op = DP_CAP_RD;
            S_CAP_WR:    cmd.op = DP_CAP_WR;
            S_CLR_FLOW:  cmd.op = DP_CLR_FLOW;
            S_BFS_INIT:  cmd.op = DP_BFS_INIT;
            S_DEQ_RD:    cmd.op = status.q_empty ? DP_IDLE : DP_DEQ_RD;
            S_DEQ:       cmd.op = DP_DEQ;
            S_SCAN_RD:   cmd.op = DP_SCAN_RD;
            S_SCAN_CHK:  cmd.op = DP_SCAN_CHK;
            S_PATH_INIT: cmd.op = DP_PATH_INIT;
            S_MIN_PAR:   cmd.op = status.at_src ? DP_UPD_INIT : DP_MIN_PAR;
            S_MIN_EDGE:  cmd.op = DP_MIN_EDGE;
            S_MIN_ACC:   cmd.op = DP_MIN_ACC;
            S_UPD_PAR:   cmd.op = status.at_src ? DP_TOTAL : DP_UPD_PAR;
            S_UPD_EDGE:  cmd.op = DP_UPD_EDGE;
            S_UPD_FWD:   cmd.op = DP_UPD_FWD;
            S_UPD_REV:   cmd.op = DP_UPD_REV;
            S_EMIT:      cmd.op = status.out_free ? DP_EMIT : DP_IDLE;
            default:     cmd.op = DP_IDLE;
        endcase
    end

endmodule

>>> rtl/core/mfek_datapath.sv
`include "max_flow_edmonds_karp_top_assert.svh"
module mfek_datapath
    import mfek_pkg::*;
#(
    parameter int NODES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [1:0]         in_op,
    input  logic [NODE_W-1:0]  in_from,
    input  logic [NODE_W-1:0]  in_to,
    input  logic [CAP_W-1:0]   in_cap,
    input  logic [NODE_W-1:0]  src_node,
    input  logic [NODE_W-1:0]  dst_node,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [TOTAL_W-1:0] out_flow
);

    localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int MAW = 2 * NW;
    localparam int MD  = 1 << MAW;

    logic [CAP_W-1:0]  cap_mem  [MD];
    logic [FLOW_W-1:0] flow_mem [MD];
    logic [NW-1:0]     par_mem  [NODES];
    logic [NW-1:0]     que_mem  [NODES];

    logic [CAP_W-1:0]   cap_q;
    logic [FLOW_W-1:0]  flow_q;
    logic [NW-1:0]      par_q;
    logic [NW-1:0]      que_q;

    logic [NW-1:0]      from_reg;
    logic [NW-1:0]      to_reg;
    logic [CAP_W-1:0]   cap_in_reg;
    logic               addr_ok_reg;
    logic [MAW-1:0]     sweep_reg;
    logic [NW-1:0]      u_reg;
    logic [NW-1:0]      v_reg;
    logic [NW-1:0]      i_reg;
    logic [NW-1:0]      p_reg;
    logic [NW:0]        head_reg;
    logic [NW:0]        tail_reg;
    logic [NODES-1:0]   valid_reg;
    logic [PUSH_W-1:0]  push_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] out_flow_reg;

    logic [NW-1:0]      src_n;
    logic [NW-1:0]      dst_n;
    logic               mem_rd;
    logic [MAW-1:0]     rd_addr;
    logic               cap_we;
    logic               flow_we;
    logic [MAW-1:0]     wr_addr;
    logic [CAP_W-1:0]   cap_wd;
    logic [FLOW_W-1:0]  flow_wd;
    logic [CAP_W:0]     cap_sum;
    logic signed [RES_W-1:0] res;
    logic [PUSH_W-1:0]  res_ext;
    logic               hit;
    logic               q_room;
    logic [TOTAL_W-1:0] room;
    logic               par_we;
    logic [NW-1:0]      par_waddr;
    logic [NW-1:0]      par_wd;
    logic               que_we;
    logic [NW-1:0]      que_waddr;

    assign src_n   = NW'(src_node);
    assign dst_n   = NW'(dst_node);
    assign cap_sum = {1'b0, cap_q} + {1'b0, cap_in_reg};
    assign res     = $signed({2'b00, cap_q}) - $signed({{2{flow_q[FLOW_W-1]}}, flow_q});
    assign res_ext = {{(PUSH_W-RES_W){res[RES_W-1]}}, res};
    assign hit     = (res > 0) && !valid_reg[v_reg];
    assign q_room  = tail_reg < (NW+1)'(NODES);
    assign room    = TOTAL_MAX - total_reg;

    assign status.sweep_last = &sweep_reg;
    assign status.run_bad    = (32'(src_node) >= NODES) || (32'(dst_node) >= NODES)
                               || (src_node == dst_node);
    assign status.q_empty    = head_reg == tail_reg;
    assign status.v_last     = v_reg == NW'(NODES - 1);
    assign status.hit_dst    = hit && (v_reg == dst_n);
    assign status.at_src     = i_reg == src_n;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_flow  = out_flow_reg;

    // matrix port control
    always_comb
    begin
        mem_rd  = 1'b0;
        rd_addr = {u_reg, v_reg};
        cap_we  = 1'b0;
        flow_we = 1'b0;
        wr_addr = sweep_reg;
        cap_wd  = '0;
        flow_wd = '0;
        case (cmd.op)
            DP_CAP_RD:
            begin
                mem_rd  = 1'b1;
                rd_addr = {from_reg, to_reg};
            end
            DP_CAP_WR:
            begin
                cap_we  = addr_ok_reg;
                wr_addr = {from_reg, to_reg};
                cap_wd  = cap_sum[CAP_W] ? CAP_MAX : cap_sum[CAP_W-1:0];
            end
            DP_CLR_ALL:
            begin
                cap_we  = 1'b1;
                flow_we = 1'b1;
            end
            DP_CLR_FLOW: flow_we = 1'b1;
            DP_SCAN_RD:  mem_rd = 1'b1;
            DP_MIN_EDGE, DP_UPD_EDGE:
            begin
                mem_rd  = 1'b1;
                rd_addr = {par_q, i_reg};
            end
            DP_UPD_FWD:
            begin
                flow_we = 1'b1;
                wr_addr = {p_reg, i_reg};
                flow_wd = flow_q + push_reg[FLOW_W-1:0];
                mem_rd  = 1'b1;
                rd_addr = {i_reg, p_reg};
            end
            DP_UPD_REV:
            begin
                flow_we = 1'b1;
                wr_addr = {i_reg, p_reg};
                flow_wd = flow_q - push_reg[FLOW_W-1:0];
            end
            default:
            begin
                mem_rd = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        par_we    = 1'b0;
        par_waddr = v_reg;
        par_wd    = u_reg;
        que_we    = 1'b0;
        que_waddr = tail_reg[NW-1:0];
        case (cmd.op)
            DP_BFS_INIT:
            begin
                par_we    = 1'b1;
                par_waddr = src_n;
                par_wd    = src_n;
                que_we    = 1'b1;
                que_waddr = '0;
            end
            DP_SCAN_CHK:
            begin
                par_we = hit;
                que_we = hit && (v_reg != dst_n) && q_room;
            end
            default:
            begin
                par_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_mem[wr_addr] <= cap_wd;
        end
        if (flow_we)
        begin
            flow_mem[wr_addr] <= flow_wd;
        end
        if (mem_rd)
        begin
            cap_q  <= cap_mem[rd_addr];
            flow_q <= flow_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wd;
        end
        if (que_we)
        begin
            que_mem[que_waddr] <= (cmd.op == DP_BFS_INIT) ? src_n : v_reg;
        end
        if (cmd.op == DP_MIN_PAR || cmd.op == DP_UPD_PAR)
        begin
            par_q <= par_mem[i_reg];
        end
        if (cmd.op == DP_DEQ_RD)
        begin
            que_q <= que_mem[head_reg[NW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                from_reg    <= NW'(in_from);
                to_reg      <= NW'(in_to);
                cap_in_reg  <= in_cap;
                addr_ok_reg <= (32'(in_from) < NODES) && (32'(in_to) < NODES);
            end
            DP_DEQ:
            begin
                u_reg <= que_q;
                v_reg <= '0;
            end
            DP_SCAN_CHK: v_reg <= v_reg + 1'b1;
            DP_PATH_INIT:
            begin
                i_reg    <= dst_n;
                push_reg <= PUSH_START;
            end
            DP_UPD_INIT: i_reg <= dst_n;
            DP_MIN_EDGE, DP_UPD_EDGE: p_reg <= par_q;
            DP_MIN_ACC:
            begin
                if ($signed(res_ext) < $signed(push_reg))
                begin
                    push_reg <= res_ext;
                end
                i_reg <= p_reg;
            end
            DP_UPD_REV: i_reg <= p_reg;
            default:
            begin
                u_reg <= u_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            valid_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_flow_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (cmd.op != DP_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                DP_LOAD:
                begin
                    if (in_op == OP_RUN || in_op == OP_CLEAR)
                    begin
                        total_reg <= '0;
                    end
                end
                DP_CLR_ALL, DP_CLR_FLOW: sweep_reg <= sweep_reg + 1'b1;
                DP_BFS_INIT:
                begin
                    // only the source is visited at the start of a search
                    valid_reg <= {{(NODES-1){1'b0}}, 1'b1} << src_n;
                    head_reg  <= '0;
                    tail_reg  <= (NW+1)'(1);
                end
                DP_DEQ: head_reg <= head_reg + 1'b1;
                DP_SCAN_CHK:
                begin
                    if (hit)
                    begin
                        valid_reg[v_reg] <= 1'b1;
                        if ((v_reg != dst_n) && q_room)
                        begin
                            tail_reg <= tail_reg + 1'b1;
                        end
                    end
                end
                DP_TOTAL:
                begin
                    if (push_reg > {{(PUSH_W-TOTAL_W){1'b0}}, room})
                    begin
                        total_reg <= TOTAL_MAX;
                    end
                    else
                    begin
                        total_reg <= total_reg + push_reg[TOTAL_W-1:0];
                    end
                end
                DP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_flow_reg  <= total_reg;
                end
                default:
                begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    `MFEK_ASSERT_HOLDS(a_tail_bound, tail_reg <= (NW+1)'(NODES))
    `MFEK_ASSERT_HOLDS(a_head_le_tail, head_reg <= tail_reg)
    `MFEK_ASSERT_NEXT(a_push_pos, cmd.op == DP_UPD_INIT, !push_reg[PUSH_W-1] && push_reg != '0)
    `MFEK_ASSERT_NEXT(a_total_up, cmd.op == DP_TOTAL, total_reg >= $past(total_reg))

endmodule

>>> rtl/core/max_flow_edmonds_karp_top.sv
// A clear keeps tready low while it sweeps the whole matrix; an add while it updates one entry.
// Run: a sweep zeroes the flow; each search dequeues nodes and scans their neighbours in turn
//   (an empty-queue check ends it when no path is left, and the result is emitted); a found
//   path is walked for its bottleneck, then to update the flow; single-port matrix reads pace it.
// Throughput: one item at a time; ready is high only while idle.
// Reset: asynchronous, active low; a clear of the whole matrix runs first.
module max_flow_edmonds_karp_top
    import mfek_pkg::*;
#(
    parameter int NODES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], from_node[7:2], to_node[13:8], capacity[61:14], zero pad
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // max_flow[53:0], zero pad
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    logic [NODE_W-1:0]  source_reg;
    logic [NODE_W-1:0]  sink_reg;
    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [TOTAL_W-1:0] flow_out;

    // configuration registers; the user must write them only while idle; the block has no check for this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= '0;
            sink_reg   <= NODE_W'(63);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE: source_reg <= cfg_data;
                REG_SINK:   sink_reg   <= cfg_data;
                default:    source_reg <= source_reg;
            endcase
        end
    end

    // sequencer: steps the search, bottleneck walk and flow update
    mfek_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tdata[1:0]),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    // matrices, search scratch, total and the result register
    mfek_datapath #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_axis_tdata[1:0]),
        .in_from   (s_axis_tdata[7:2]),
        .in_to     (s_axis_tdata[13:8]),
        .in_cap    (s_axis_tdata[61:14]),
        .src_node  (source_reg),
        .dst_node  (sink_reg),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_flow  (flow_out)
    );

    assign m_axis_tdata = {2'b00, flow_out};

endmodule

>>> test/max_flow_edmonds_karp_checker.sv
`timescale 1ns / 100ps

module max_flow_edmonds_karp_checker
    import mfek_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output int          fail_count,
    output int          pending_flows,
    output int          flows_seen
);

    localparam int N = 64;

    logic [CAP_W-1:0]   cap_mx [N*N];
    logic signed [63:0] flow_mx [N*N];
    logic [NODE_W-1:0]  src_q;
    logic [NODE_W-1:0]  dst_q;
    logic [TOTAL_W-1:0] flows_due [$];

    function automatic logic signed [63:0] resid(int u, int v);
        return $signed({16'd0, cap_mx[u*N+v]}) - flow_mx[u*N+v];
    endfunction

    // Edmonds-Karp on the model matrices, neighbours in ascending order
    function automatic logic [TOTAL_W-1:0] max_flow_of_graph();
        logic [TOTAL_W-1:0] tot;
        logic signed [63:0] push;
        logic signed [63:0] r;
        bit   seen [N];
        int   par [N];
        int   fifo [N];
        int   hd;
        int   tl;
        int   u;
        int   i;
        bit   hit;
        tot = '0;
        for (int k = 0; k < N*N; k++) flow_mx[k] = 0;
        if (src_q == dst_q) return '0;
        forever
        begin
            for (int k = 0; k < N; k++) seen[k] = 0;
            seen[src_q] = 1;
            par[src_q]  = src_q;
            hd = 0;
            tl = 0;
            fifo[tl++] = src_q;
            hit = 0;
            while (hd < tl && !hit)
            begin
                u = fifo[hd++];
                for (int v = 0; v < N && !hit; v++)
                begin
                    if (!seen[v] && resid(u, v) > 0)
                    begin
                        seen[v] = 1;
                        par[v]  = u;
                        if (v == dst_q) hit = 1;
                        else if (tl < N) fifo[tl++] = v;
                    end
                end
            end
            if (!hit) break;
            push = 64'sd1000000000000000000;
            for (i = dst_q; i != src_q; i = par[i])
            begin
                r = resid(par[i], i);
                if (r < push) push = r;
            end
            for (i = dst_q; i != src_q; i = par[i])
            begin
                flow_mx[par[i]*N+i] += push;
                flow_mx[i*N+par[i]] -= push;
            end
            if (push > $signed({10'd0, TOTAL_MAX - tot})) tot = TOTAL_MAX;
            else tot += push[TOTAL_W-1:0];
        end
        return tot;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] flow check: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [1:0]         op;
        logic [NODE_W-1:0]  fu;
        logic [NODE_W-1:0]  tv;
        logic [CAP_W-1:0]   c;
        logic [CAP_W:0]     sum;
        logic [TOTAL_W-1:0] want;
        if (!rst_n)
        begin
            for (int k = 0; k < N*N; k++)
            begin
                cap_mx[k]  = '0;
                flow_mx[k] = 0;
            end
            src_q = '0;
            dst_q = 6'd63;
            flows_due.delete();
            fail_count    = 0;
            pending_flows = 0;
            flows_seen    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SOURCE) src_q = cfg_data;
                else dst_q = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                op = s_axis_tdata[1:0];
                fu = s_axis_tdata[7:2];
                tv = s_axis_tdata[13:8];
                c  = s_axis_tdata[61:14];
                if (op == OP_CLEAR)
                begin
                    for (int k = 0; k < N*N; k++) cap_mx[k] = '0;
                end
                else if (op == OP_ADD)
                begin
                    sum = cap_mx[fu*N+tv] + c;
                    cap_mx[fu*N+tv] = sum[CAP_W] ? CAP_MAX : sum[CAP_W-1:0];
                end
                else if (op == OP_RUN)
                    flows_due = {flows_due, max_flow_of_graph()};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                flows_seen++;
                if (flows_due.size() == 0)
                    report_mismatch("unexpected flow result", m_axis_tdata, 0);
                else
                begin
                    want = flows_due.pop_front();
                    if (m_axis_tdata[TOTAL_W-1:0] !== want)
                        report_mismatch("max_flow", m_axis_tdata[TOTAL_W-1:0], want);
                    if (m_axis_tdata[55:TOTAL_W] !== '0)
                        report_mismatch("pad bits", m_axis_tdata[55:TOTAL_W], 0);
                end
            end
            pending_flows = flows_due.size();
        end
    end

endmodule

>>> test/max_flow_edmonds_karp_top_tb.sv
`timescale 1ns / 100ps

module max_flow_edmonds_karp_top_tb;
    import mfek_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [5:0]  cfg_data;

    int  fail_count;
    int  pending_flows;
    int  flows_seen;
    int  items_sent;
    bit  calm;           // no idling on either side in the closing phase

    max_flow_edmonds_karp_top i_dut (.*);

    max_flow_edmonds_karp_checker i_chk (.*);

    always #2 clk = ~clk;

    // Sink side: ready drops for random bursts until the closing phase
    always @(posedge clk)
    begin
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    // One transfer, sometimes after a random idle burst. tvalid stays high afterwards so
    // items can follow back to back; quiet_input drops it before any wait.
    task automatic send_item(input logic [1:0] op, input logic [5:0] fu,
                             input logic [5:0] tv, input logic [47:0] c);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c, tv, fu, op};
        @(posedge clk iff s_axis_tready);
        items_sent++;
    endtask

    task automatic add_edge(input logic [5:0] fu, input logic [5:0] tv,
                            input logic [47:0] c);
        send_item(OP_ADD, fu, tv, c);
    endtask

    // Stop offering items, drain outstanding runs and wait for the engine to idle
    task automatic quiet_input();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_flows != 0) @(posedge clk);
        @(posedge clk iff s_axis_tready);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [5:0] val);
        quiet_input();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [47:0] rand_cap();
        case ($urandom_range(0, 3))
            0: return 48'($urandom_range(0, 20));
            1: return 48'({$urandom, $urandom});
            2: return CAP_MAX - 48'($urandom_range(0, 3));
            default: return 48'($urandom_range(0, 100000));
        endcase
    endfunction

    // Few nodes around source/sink keep the searches short and paths common
    function automatic logic [5:0] pick_node(input logic [5:0] s, input logic [5:0] t);
        case ($urandom_range(0, 5))
            0: return s;
            1: return t;
            2: return 6'($urandom_range(0, 63));
            default: return 6'($urandom_range(0, 7) + 6'(s & 6'h38));
        endcase
    endfunction

    initial
    begin
        logic [5:0] s;
        logic [5:0] t;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SOURCE;
        cfg_data      = '0;
        calm          = 1'b0;
        items_sent    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset source 0, sink 63
        send_item(OP_RUN, 6'd0, 6'd0, 48'd0);        // empty graph
        add_edge(6'd0, 6'd63, CAP_MAX);
        add_edge(6'd0, 6'd63, 48'd5);                // saturates
        add_edge(6'd0, 6'd1, 48'd7);
        add_edge(6'd1, 6'd63, 48'd3);
        add_edge(6'd1, 6'd1, 48'd9);                 // self-loop
        add_edge(6'd63, 6'd0, 48'd4);
        send_item(OP_RUN, 6'd0, 6'd0, 48'd0);
        send_item(2'd3, 6'h3f, 6'h3f, CAP_MAX);      // unknown opcode ignored
        send_item(OP_RUN, 6'd0, 6'd0, 48'd0);        // repeated run, same answer
        send_item(OP_CLEAR, 6'h15, 6'h2a, 48'haaaa_5555_aaaa);
        add_edge(6'd0, 6'd2, 48'd10);
        add_edge(6'd2, 6'd3, 48'd4);
        add_edge(6'd3, 6'd63, 48'd10);
        add_edge(6'd0, 6'd3, 48'd6);
        add_edge(6'd2, 6'd63, 48'd2);
        send_item(OP_RUN, 6'd0, 6'd0, 48'd0);
        set_reg(REG_SINK, 6'd0);                     // source equals sink
        send_item(OP_RUN, 6'd0, 6'd0, 48'd0);
        set_reg(REG_SOURCE, 6'd63);                  // reverse direction
        send_item(OP_RUN, 6'd0, 6'd0, 48'd0);

        // Random phases, each with its own source/sink
        for (int ph = 0; ph < 14; ph++)
        begin
            s = (ph % 4 == 0) ? 6'd0 : 6'($urandom_range(0, 63));
            t = (ph % 4 == 1) ? 6'd63 : 6'($urandom_range(0, 63));
            if (ph == 5) t = s;
            set_reg(REG_SOURCE, s);
            set_reg(REG_SINK, t);
            send_item(OP_CLEAR, 6'($urandom), 6'($urandom), rand_cap());
            for (int k = 0; k < 30; k++)
            begin
                if (ph >= 11) calm = 1'b1;
                case ($urandom_range(0, 19))
                    0: send_item(OP_RUN, 6'($urandom), 6'($urandom), rand_cap());
                    1: send_item(2'd3, 6'($urandom), 6'($urandom), rand_cap());
                    2: if ($urandom_range(0, 3) == 0)
                           send_item(OP_CLEAR, 6'($urandom), 6'($urandom), rand_cap());
                    default: add_edge(pick_node(s, t), pick_node(s, t), rand_cap());
                endcase
            end
            send_item(OP_RUN, 6'd0, 6'd0, 48'd0);
        end

        quiet_input();
        repeat (200) @(posedge clk);
        $display("Sent %0d items; %0d max-flow results checked over 17 source/sink settings.",
                 items_sent, flows_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
